[hw/rtl/bpa_pkg.sv]
package bpa_pkg;

   // default geometry of the used-bit map
   localparam int DEF_MAP_PAGES     = 32768;
   localparam int DEF_MAP_WORD_BITS = 32;

   // managed region and page geometry
   localparam logic [31:0] BASE_ADDR      = 32'h0020_0000;
   localparam int          PAGE_SHIFT     = 12;
   localparam int          FALLBACK_PAGES = 1024;
   localparam logic [21:0] BASE_KB        = 22'd2048;

   // configuration register
   localparam int SIZE_KB_BITS = 22;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 2;

   // request kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STAT_GRANTED = 2'd0,
      STAT_NO_MEM  = 2'd1,
      STAT_FREED   = 2'd2,
      STAT_IGNORED = 2'd3
   } status_type;

endpackage

[hw/rtl/bpa_map_mem.sv]
module bpa_map_mem #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] map_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/bpa_bit_find.sv]
module bpa_bit_find #(
   parameter int WIDTH = 32
) (
   input  logic [WIDTH-1:0]         word,
   input  logic [WIDTH-1:0]         mask,
   output logic                     found,
   output logic [$clog2(WIDTH)-1:0] index
);

   localparam int IW = $clog2(WIDTH);

   logic [WIDTH-1:0] cand;

   // lowest clear bit among the enabled ones
   assign cand = ~word & mask;

   always_comb begin
      found = 1'b0;
      index = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (cand[i]) begin
            found = 1'b1;
            index = IW'(i);
         end
      end
   end

endmodule

[hw/rtl/bitmap_page_allocator.sv]
// First-fit 4 KiB page allocator over a used-bit map held in one RAM word array.
// Request side: start/busy. A word is taken at a clock edge with start high and
// busy low; req_kind selects allocate or free, req_free_address names the page
// to free. Each request gives one response word unless a CSR write cuts it
// short; it is shown for one cycle with rsp_valid high; the receiver cannot stall it.
// Path through the states: allocate with nothing free (hint at or past the
// count) goes from ST_IDLE straight to ST_RESP; free goes through ST_FCHECK,
// or straight to ST_RESP when the address is below the base or past the count;
// allocate walks ST_SCAN a map word at a time until it has granted a page and
// found the next free page or reached the end of the map, then goes to ST_RESP.
// Throughput is one request at a time; the map RAM read port, one map word per
// cycle, sets the walk length.
// CSR: APB write of memory_size_kb at any offset resets the map. After reset and
// after each such write the map RAM is swept clear, one word per cycle, over all
// MAP_WORDS words (1024 by default); busy stays high meanwhile.
// Reset is synchronous; rsp_valid is low while it is applied.
module bitmap_page_allocator
#(
   parameter int MAP_PAGES     = bpa_pkg::DEF_MAP_PAGES,
   parameter int MAP_WORD_BITS = bpa_pkg::DEF_MAP_WORD_BITS
) (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [31:0] req_free_address,
   // response
   output logic        rsp_valid,
   output logic [31:0] rsp_page_address,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_used_page_count,
   output logic [15:0] rsp_free_page_count,
   output logic [17:0] rsp_total_kb,
   output logic [17:0] rsp_used_kb,
   output logic [17:0] rsp_free_kb,
   // CSR
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [bpa_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [bpa_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [bpa_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready
);

   import bpa_pkg::*;

   // map geometry; MAP_WORD_BITS is a power of two so a page is {word, bit}
   localparam int MAP_WORDS = (MAP_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WW  = $clog2(MAP_WORDS);
   localparam int BW  = $clog2(MAP_WORD_BITS);
   localparam int PIW = WW + BW;          // page index
   localparam int PW  = PIW + 1;          // page count, may equal MAP_PAGES
   localparam int RESET_PAGES = (FALLBACK_PAGES < MAP_PAGES) ? FALLBACK_PAGES : MAP_PAGES;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FCHECK,
      ST_RESP
   } state_type;

   state_type              state_ff;
   logic [WW-1:0]          clr_idx_ff;
   logic [WW-1:0]          scan_word_ff;
   logic [BW-1:0]          scan_lo_ff;
   logic                   fwd_ff;
   logic [MAP_WORD_BITS-1:0] fwd_word_ff;
   logic                   granted_ff;
   logic [PIW-1:0]         grant_page_ff;
   logic [PIW-1:0]         free_page_ff;
   logic [PW-1:0]          used_ff;
   logic [PW-1:0]          hint_ff;
   logic [PW-1:0]          page_total_ff;
   logic [SIZE_KB_BITS-1:0] size_kb_ff;
   status_type             res_status_ff;

   logic        rsp_valid_ff;
   logic [31:0] rsp_page_address_ff;
   logic [1:0]  rsp_status_ff;
   logic [15:0] rsp_used_ff;
   logic [15:0] rsp_free_ff;
   logic [17:0] rsp_total_kb_ff;
   logic [17:0] rsp_used_kb_ff;
   logic [17:0] rsp_free_kb_ff;

   // map RAM ports
   logic                     mem_wr_en;
   logic [WW-1:0]            mem_wr_addr;
   logic [MAP_WORD_BITS-1:0] mem_wr_data;
   logic [WW-1:0]            mem_rd_addr;
   logic [MAP_WORD_BITS-1:0] mem_rd_data;

   // scan datapath
   logic [MAP_WORD_BITS-1:0] scan_data;
   logic [MAP_WORD_BITS-1:0] scan_mask;
   logic                     fnd;
   logic [BW-1:0]            fnd_bit;
   logic [PIW-1:0]           fnd_page;
   logic [PW-1:0]            next_base;
   logic                     scan_end;
   logic [MAP_WORD_BITS-1:0] scan_set;

   // free address decode
   logic        free_below;
   logic [31:0] free_off;
   logic [19:0] free_pg20;
   logic        free_in_range;
   logic [PIW-1:0] free_pg;
   logic        free_bit;

   // CSR
   logic                    csr_wr;
   logic [SIZE_KB_BITS-1:0] csr_kb;
   logic [19:0]             csr_raw_pages;
   logic [PW-1:0]           csr_pages;

   logic [PW-1:0] stat_free;

   bpa_map_mem #(
      .DEPTH (MAP_WORDS),
      .WIDTH (MAP_WORD_BITS)
   ) u_map (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // after a grant the updated word is searched again from the register copy
   assign scan_data = fwd_ff ? fwd_word_ff : mem_rd_data;

   // candidates: at or above the start bit and below the managed page count
   always_comb begin
      for (int b = 0; b < MAP_WORD_BITS; b++) begin
         scan_mask[b] = (PW'({scan_word_ff, BW'(b)}) < page_total_ff) &&
                        (BW'(b) >= scan_lo_ff);
      end
   end

   bpa_bit_find #(
      .WIDTH (MAP_WORD_BITS)
   ) u_find (
      .word  (scan_data),
      .mask  (scan_mask),
      .found (fnd),
      .index (fnd_bit)
   );

   assign fnd_page  = {scan_word_ff, fnd_bit};
   assign next_base = PW'({scan_word_ff, {BW{1'b0}}}) + PW'(MAP_WORD_BITS);
   assign scan_end  = next_base >= page_total_ff;
   assign scan_set  = scan_data | (MAP_WORD_BITS'(1) << fnd_bit);

   assign free_below    = req_free_address < BASE_ADDR;
   assign free_off      = req_free_address - BASE_ADDR;
   assign free_pg20     = free_off[31:PAGE_SHIFT];
   assign free_in_range = !free_below && (32'(free_pg20) < 32'(page_total_ff));
   assign free_pg       = free_pg20[PIW-1:0];
   assign free_bit      = mem_rd_data[free_page_ff[BW-1:0]];

   // page count from memory size: (kb - 2 MiB in KiB) / 4, or the fallback; capped at MAP_PAGES
   assign csr_wr = psel && penable && pwrite && pready;
   assign csr_kb = pwdata[SIZE_KB_BITS-1:0];

   always_comb begin
      if (csr_kb > BASE_KB) begin
         csr_raw_pages = 20'((csr_kb - BASE_KB) >> 2);
      end else begin
         csr_raw_pages = 20'(FALLBACK_PAGES);
      end
      if (32'(csr_raw_pages) > 32'(MAP_PAGES)) begin
         csr_pages = PW'(MAP_PAGES);
      end else begin
         csr_pages = PW'(csr_raw_pages);
      end
   end

   // map RAM access
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = scan_word_ff;
      mem_wr_data = '0;
      mem_rd_addr = scan_word_ff + WW'(1);
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_idx_ff;
         end
         ST_IDLE: begin
            if (req_kind == KIND_FREE) begin
               mem_rd_addr = free_pg[PIW-1:BW];
            end else begin
               mem_rd_addr = hint_ff[PIW-1:BW];
            end
         end
         ST_SCAN: begin
            if (fnd && !granted_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = scan_set;
            end
         end
         ST_FCHECK: begin
            mem_wr_addr = free_page_ff[PIW-1:BW];
            mem_wr_en   = free_bit;
            mem_wr_data = mem_rd_data & ~(MAP_WORD_BITS'(1) << free_page_ff[BW-1:0]);
         end
         default: begin
         end
      endcase
   end

   assign stat_free = page_total_ff - used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_idx_ff    <= '0;
         used_ff       <= '0;
         hint_ff       <= '0;
         page_total_ff <= PW'(RESET_PAGES);
         size_kb_ff    <= '0;
         fwd_ff        <= 1'b0;
         granted_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_wr) begin
            // reinit: new page count, empty map
            size_kb_ff    <= csr_kb;
            page_total_ff <= csr_pages;
            used_ff       <= '0;
            hint_ff       <= '0;
            clr_idx_ff    <= '0;
            state_ff      <= ST_CLEAR;
         end else begin
            case (state_ff)
               ST_CLEAR: begin
                  clr_idx_ff <= clr_idx_ff + WW'(1);
                  if (clr_idx_ff == WW'(MAP_WORDS - 1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
               ST_IDLE: begin
                  if (start) begin
                     granted_ff <= 1'b0;
                     fwd_ff     <= 1'b0;
                     if (req_kind == KIND_ALLOC) begin
                        if (hint_ff >= page_total_ff) begin
                           res_status_ff <= STAT_NO_MEM;
                           state_ff      <= ST_RESP;
                        end else begin
                           scan_word_ff <= hint_ff[PIW-1:BW];
                           scan_lo_ff   <= hint_ff[BW-1:0];
                           state_ff     <= ST_SCAN;
                        end
                     end else begin
                        if (free_in_range) begin
                           free_page_ff <= free_pg;
                           state_ff     <= ST_FCHECK;
                        end else begin
                           res_status_ff <= STAT_IGNORED;
                           state_ff      <= ST_RESP;
                        end
                     end
                  end
               end
               ST_SCAN: begin
                  if (fnd) begin
                     if (!granted_ff) begin
                        // grant, then look for the next free page, starting in the same word
                        granted_ff    <= 1'b1;
                        grant_page_ff <= fnd_page;
                        used_ff       <= used_ff + PW'(1);
                        fwd_ff        <= 1'b1;
                        fwd_word_ff   <= scan_set;
                        scan_lo_ff    <= fnd_bit;
                     end else begin
                        hint_ff       <= PW'(fnd_page);
                        res_status_ff <= STAT_GRANTED;
                        state_ff      <= ST_RESP;
                     end
                  end else if (scan_end) begin
                     if (granted_ff) begin
                        // map exhausted above the granted page
                        hint_ff       <= page_total_ff;
                        res_status_ff <= STAT_GRANTED;
                     end else begin
                        res_status_ff <= STAT_NO_MEM;
                     end
                     state_ff <= ST_RESP;
                  end else begin
                     scan_word_ff <= scan_word_ff + WW'(1);
                     scan_lo_ff   <= '0;
                     fwd_ff       <= 1'b0;
                  end
               end
               ST_FCHECK: begin
                  if (free_bit) begin
                     used_ff <= used_ff - PW'(1);
                     if (PW'(free_page_ff) < hint_ff) begin
                        hint_ff <= PW'(free_page_ff);
                     end
                     res_status_ff <= STAT_FREED;
                  end else begin
                     res_status_ff <= STAT_IGNORED;
                  end
                  state_ff <= ST_RESP;
               end
               ST_RESP: begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  if (res_status_ff == STAT_GRANTED) begin
                     rsp_page_address_ff <= BASE_ADDR +
                                            32'({grant_page_ff, {PAGE_SHIFT{1'b0}}});
                  end else begin
                     rsp_page_address_ff <= '0;
                  end
                  rsp_used_ff     <= 16'(used_ff);
                  rsp_free_ff     <= 16'(stat_free);
                  rsp_total_kb_ff <= 18'({page_total_ff, 2'b00});
                  rsp_used_kb_ff  <= 18'({used_ff, 2'b00});
                  rsp_free_kb_ff  <= 18'({stat_free, 2'b00});
                  state_ff        <= ST_IDLE;
               end
               default: begin
                  state_ff <= ST_IDLE;
               end
            endcase
         end
      end
   end

   assign busy = (state_ff != ST_IDLE);

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_page_address    = rsp_page_address_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_used_page_count = rsp_used_ff;
   assign rsp_free_page_count = rsp_free_ff;
   assign rsp_total_kb        = rsp_total_kb_ff;
   assign rsp_used_kb         = rsp_used_kb_ff;
   assign rsp_free_kb         = rsp_free_kb_ff;

   // single register; every offset decodes to it
   assign prdata = CSR_DATA_BITS'(size_kb_ff);
   assign pready = 1'b1;

   logic unused_paddr;
   assign unused_paddr = ^paddr;

endmodule
